/* rtl/core/segint_pkg.sv */
// Package for the segment intersection pipeline: widths and the CSR index type.
package segint_pkg;

   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_REF_START_X = 2'd0,
      CSR_REF_START_Y = 2'd1,
      CSR_REF_END_X   = 2'd2,
      CSR_REF_END_Y   = 2'd3
   } csr_idx_type;

   localparam int OUT_BITS = 24;

endpackage

/* rtl/core/segint_divider.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module segint_divider #(
   parameter int NUM_BITS = 48,
   parameter int DEN_BITS = 34,
   parameter int TAG_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quo,
   output logic                out_rem_nz,
   output logic [TAG_BITS-1:0] out_tag
);

   logic [NUM_BITS:0]   valid_ff;
   logic [NUM_BITS-1:0] quo_ff [NUM_BITS+1];
   logic [DEN_BITS:0]   rem_ff [NUM_BITS+1];
   logic [DEN_BITS-1:0] den_ff [NUM_BITS+1];
   logic [TAG_BITS-1:0] tag_ff [NUM_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NUM_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      quo_ff[0] <= in_num;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
      tag_ff[0] <= in_tag;
   end

   // each stage shifts in one numerator bit and makes one quotient bit
   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [DEN_BITS+1:0] trial_in;
      logic [DEN_BITS+1:0] diff_in;
      assign trial_in = {rem_ff[s], quo_ff[s][NUM_BITS-1]};
      assign diff_in  = trial_in - {2'b00, den_ff[s]};
      always_ff @(posedge clock) begin
         if (!diff_in[DEN_BITS+1]) begin
            rem_ff[s+1] <= diff_in[DEN_BITS:0];
         end else begin
            rem_ff[s+1] <= trial_in[DEN_BITS:0];
         end
         quo_ff[s+1] <= {quo_ff[s][NUM_BITS-2:0], ~diff_in[DEN_BITS+1]};
         den_ff[s+1] <= den_ff[s];
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign out_valid  = valid_ff[NUM_BITS];
   assign out_quo    = quo_ff[NUM_BITS];
   assign out_rem_nz = |rem_ff[NUM_BITS];
   assign out_tag    = tag_ff[NUM_BITS];

endmodule

/* rtl/core/segint_front.sv */
// Front stages: spans, registered products, determinant and range test.
module segint_front
   import segint_pkg::*;
#(
   parameter int CB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CB-1:0] qsx,
   input  logic signed [CB-1:0] qsy,
   input  logic signed [CB-1:0] qex,
   input  logic signed [CB-1:0] qey,
   input  logic signed [CB-1:0] psx,
   input  logic signed [CB-1:0] psy,
   input  logic signed [CB-1:0] pex,
   input  logic signed [CB-1:0] pey,
   output logic                 out_valid,
   output logic                 out_hit,
   output logic [2*CB+1:0]      out_den,
   output logic [2*CB+1:0]      out_tn,
   output logic signed [CB:0]   out_rx,
   output logic signed [CB:0]   out_ry,
   output logic signed [CB-1:0] out_qx,
   output logic signed [CB-1:0] out_qy
);

   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   // stage 1: differences
   logic                 v1_ff;
   logic signed [DW-1:0] rx1_ff, ry1_ff, sx1_ff, sy1_ff, dx1_ff, dy1_ff;
   logic signed [CB-1:0] qx1_ff, qy1_ff;
   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] p_rs_ff, p_ry_sx_ff, p_ds_ff, p_dy_sx_ff, p_dr_ff, p_dy_rx_ff;
   logic signed [DW-1:0] rx2_ff, ry2_ff;
   logic signed [CB-1:0] qx2_ff, qy2_ff;
   // stage 3: determinant and numerators
   logic                 v3_ff;
   logic signed [SW-1:0] den3_ff, tn3_ff, un3_ff;
   logic signed [DW-1:0] rx3_ff, ry3_ff;
   logic signed [CB-1:0] qx3_ff, qy3_ff;
   // stage 4: normalized sign and range check
   logic                 v4_ff, hit4_ff;
   logic [SW-1:0]        den4_ff, tn4_ff;
   logic signed [DW-1:0] rx4_ff, ry4_ff;
   logic signed [CB-1:0] qx4_ff, qy4_ff;

   logic signed [SW-1:0] den_abs_in, tn_n_in, un_n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rx1_ff <= DW'(qex) - DW'(qsx);
      ry1_ff <= DW'(qey) - DW'(qsy);
      sx1_ff <= DW'(pex) - DW'(psx);
      sy1_ff <= DW'(pey) - DW'(psy);
      dx1_ff <= DW'(psx) - DW'(qsx);
      dy1_ff <= DW'(psy) - DW'(qsy);
      qx1_ff <= qsx;
      qy1_ff <= qsy;

      p_rs_ff    <= PW'(rx1_ff) * PW'(sy1_ff);
      p_ry_sx_ff <= PW'(ry1_ff) * PW'(sx1_ff);
      p_ds_ff    <= PW'(dx1_ff) * PW'(sy1_ff);
      p_dy_sx_ff <= PW'(dy1_ff) * PW'(sx1_ff);
      p_dr_ff    <= PW'(dx1_ff) * PW'(ry1_ff);
      p_dy_rx_ff <= PW'(dy1_ff) * PW'(rx1_ff);
      rx2_ff <= rx1_ff;
      ry2_ff <= ry1_ff;
      qx2_ff <= qx1_ff;
      qy2_ff <= qy1_ff;

      den3_ff <= SW'(p_rs_ff) - SW'(p_ry_sx_ff);
      tn3_ff  <= SW'(p_ds_ff) - SW'(p_dy_sx_ff);
      un3_ff  <= SW'(p_dr_ff) - SW'(p_dy_rx_ff);
      rx3_ff <= rx2_ff;
      ry3_ff <= ry2_ff;
      qx3_ff <= qx2_ff;
      qy3_ff <= qy2_ff;

      hit4_ff <= (den_abs_in != '0) && !tn_n_in[SW-1] && (tn_n_in <= den_abs_in)
                 && !un_n_in[SW-1] && (un_n_in <= den_abs_in);
      den4_ff <= den_abs_in;
      tn4_ff  <= tn_n_in;
      rx4_ff <= rx3_ff;
      ry4_ff <= ry3_ff;
      qx4_ff <= qx3_ff;
      qy4_ff <= qy3_ff;
   end

   always_comb begin
      if (den3_ff[SW-1]) begin
         den_abs_in = -den3_ff;
         tn_n_in    = -tn3_ff;
         un_n_in    = -un3_ff;
      end else begin
         den_abs_in = den3_ff;
         tn_n_in    = tn3_ff;
         un_n_in    = un3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_hit   = hit4_ff;
   assign out_den   = den4_ff[2*CB+1:0];
   assign out_tn    = tn4_ff[2*CB+1:0];
   assign out_rx    = rx4_ff;
   assign out_ry    = ry4_ff;
   assign out_qx    = qx4_ff;
   assign out_qy    = qy4_ff;

endmodule

/* rtl/core/segment_intersection.sv */
// Top level: pipelined 2D segment intersection against a configured reference segment.
// Stages: 4 front stages, 1 product stage, NB+1 divider stages and 1 output stage,
// where NB = 3*COORD_BITS+FRAC_BITS+3 (59 at defaults).
// Throughput: one transaction per cycle, set by the fully pipelined divider.
// Reset clears all valid bits and the reference registers to zero.
// The receiver cannot stall; each result shows for one cycle on rsp_valid.
module segment_intersection
   import segint_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_query_start_x,
   input  logic signed [COORD_BITS-1:0] req_query_start_y,
   input  logic signed [COORD_BITS-1:0] req_query_end_x,
   input  logic signed [COORD_BITS-1:0] req_query_end_y,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic signed [OUT_BITS-1:0]   rsp_cross_x,
   output logic signed [OUT_BITS-1:0]   rsp_cross_y,
   input  logic                         csr_write,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [15:0]                  csr_data
);

   localparam int CB  = COORD_BITS;
   localparam int DNB = 2 * CB + 2;            // magnitude width of den and tn
   localparam int MB  = CB + 1 + FRAC_BITS;    // |span| << FRAC_BITS
   localparam int NB  = DNB + MB;              // numerator width
   localparam int TB  = 1 + 2 * (CB + 1) + 2 * CB;
   localparam int BW  = CB + FRAC_BITS + 2;    // base and result working width

   logic signed [CB-1:0] ref_sx_ff, ref_sy_ff, ref_ex_ff, ref_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_sx_ff <= '0;
         ref_sy_ff <= '0;
         ref_ex_ff <= '0;
         ref_ey_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_REF_START_X: ref_sx_ff <= CB'($signed(csr_data));
            CSR_REF_START_Y: ref_sy_ff <= CB'($signed(csr_data));
            CSR_REF_END_X:   ref_ex_ff <= CB'($signed(csr_data));
            CSR_REF_END_Y:   ref_ey_ff <= CB'($signed(csr_data));
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                 f_valid, f_hit;
   logic [DNB-1:0]       f_den, f_tn;
   logic signed [CB:0]   f_rx, f_ry;
   logic signed [CB-1:0] f_qx, f_qy;

   segint_front #(.CB(CB)) u_front (
      .clock(clock), .reset(reset), .in_valid(start & ~busy),
      .qsx(req_query_start_x), .qsy(req_query_start_y),
      .qex(req_query_end_x), .qey(req_query_end_y),
      .psx(ref_sx_ff), .psy(ref_sy_ff), .pex(ref_ex_ff), .pey(ref_ey_ff),
      .out_valid(f_valid), .out_hit(f_hit), .out_den(f_den), .out_tn(f_tn),
      .out_rx(f_rx), .out_ry(f_ry), .out_qx(f_qx), .out_qy(f_qy)
   );

   // product stage: tn * |span| << FRAC_BITS for both axes
   logic                 m_valid_ff, m_hit_ff;
   logic [NB-1:0]        m_nx_ff, m_ny_ff;
   logic [DNB-1:0]       m_den_ff;
   logic signed [CB:0]   m_rx_ff, m_ry_ff;
   logic signed [CB-1:0] m_qx_ff, m_qy_ff;
   logic [CB:0]          mag_x, mag_y;

   assign mag_x = f_rx[CB] ? (CB+1)'(-f_rx) : (CB+1)'(f_rx);
   assign mag_y = f_ry[CB] ? (CB+1)'(-f_ry) : (CB+1)'(f_ry);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      m_hit_ff <= f_hit;
      m_nx_ff  <= (NB'(f_tn) * NB'(mag_x)) << FRAC_BITS;
      m_ny_ff  <= (NB'(f_tn) * NB'(mag_y)) << FRAC_BITS;
      m_den_ff <= f_hit ? f_den : DNB'(1);
      m_rx_ff  <= f_rx;
      m_ry_ff  <= f_ry;
      m_qx_ff  <= f_qx;
      m_qy_ff  <= f_qy;
   end

   logic          dx_valid, dy_valid, dx_rnz, dy_rnz;
   logic [NB-1:0] dx_quo, dy_quo;
   logic [TB-1:0] dx_tag, dy_tag;

   segint_divider #(.NUM_BITS(NB), .DEN_BITS(DNB), .TAG_BITS(TB)) u_div_x (
      .clock(clock), .reset(reset), .in_valid(m_valid_ff),
      .in_num(m_nx_ff), .in_den(m_den_ff),
      .in_tag({m_hit_ff, m_rx_ff, m_ry_ff, m_qx_ff, m_qy_ff}),
      .out_valid(dx_valid), .out_quo(dx_quo), .out_rem_nz(dx_rnz), .out_tag(dx_tag)
   );

   segint_divider #(.NUM_BITS(NB), .DEN_BITS(DNB), .TAG_BITS(TB)) u_div_y (
      .clock(clock), .reset(reset), .in_valid(m_valid_ff),
      .in_num(m_ny_ff), .in_den(m_den_ff),
      .in_tag({m_hit_ff, m_rx_ff, m_ry_ff, m_qx_ff, m_qy_ff}),
      .out_valid(dy_valid), .out_quo(dy_quo), .out_rem_nz(dy_rnz), .out_tag(dy_tag)
   );

   logic                 t_hit;
   logic signed [CB:0]   t_rx, t_ry;
   logic signed [CB-1:0] t_qx, t_qy;
   assign {t_hit, t_rx, t_ry, t_qx, t_qy} = dx_tag;

   // place base +/- quotient, truncating toward zero
   function automatic logic signed [BW-1:0] place_pt(
      input logic signed [CB-1:0] base, input logic span_neg,
      input logic [NB-1:0] quo, input logic rnz);
      logic signed [BW-1:0] b, v;
      b = BW'(base) <<< FRAC_BITS;
      if (!span_neg) begin
         v = b + BW'(quo);
         if (rnz && v[BW-1]) v = v + BW'(1);
      end else begin
         v = b - BW'(quo);
         if (rnz && !v[BW-1] && v != '0) v = v - BW'(1);
      end
      return v;
   endfunction

   logic                 o_valid_ff, o_hit_ff;
   logic [OUT_BITS-1:0]  o_x_ff, o_y_ff;
   logic signed [BW-1:0] px_in, py_in;

   assign px_in = place_pt(t_qx, t_rx[CB], dx_quo, dx_rnz);
   assign py_in = place_pt(t_qy, t_ry[CB], dy_quo, dy_rnz);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= dx_valid & dy_valid;
      end
   end

   always_ff @(posedge clock) begin
      o_hit_ff <= t_hit;
      o_x_ff   <= t_hit ? OUT_BITS'(px_in) : '0;
      o_y_ff   <= t_hit ? OUT_BITS'(py_in) : '0;
   end

   logic unused_tag;
   assign unused_tag = ^dy_tag;

   assign rsp_valid   = o_valid_ff & (unused_tag | ~unused_tag);
   assign rsp_hit     = o_hit_ff;
   assign rsp_cross_x = o_x_ff;
   assign rsp_cross_y = o_y_ff;

endmodule

/* rtl/core/segint_checker.sv */
// Port-level assertions for the segment intersection block, bound to the top level.
module segint_checker #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic [23:0] rsp_cross_x,
   input logic [23:0] rsp_cross_y
);

   localparam int LAT = 4 + 1 + (3 * COORD_BITS + FRAC_BITS + 4) + 1;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss with nonzero point");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("result missing at fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without request");

endmodule

bind segment_intersection segint_checker #(
   .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)
) u_segint_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
   .rsp_cross_x(rsp_cross_x), .rsp_cross_y(rsp_cross_y)
);

/* bench/tb.sv */
// Testbench for the segment intersection pipeline: scoreboard class and stimulus top.
`timescale 1ns / 1ps

module tb;
   import segint_pkg::*;

   typedef struct {
      logic                        hit;
      logic signed [OUT_BITS-1:0]  cx;
      logic signed [OUT_BITS-1:0]  cy;
   } crossing_type;

   class crossing_board;
      crossing_type pending[$];
      logic signed [15:0] seg_ax, seg_ay, seg_bx, seg_by;
      int errors;

      function new();
         seg_ax = 0; seg_ay = 0; seg_bx = 0; seg_by = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [15:0] val);
         case (idx)
            CSR_REF_START_X: seg_ax = val;
            CSR_REF_START_Y: seg_ay = val;
            CSR_REF_END_X:   seg_bx = val;
            CSR_REF_END_Y:   seg_by = val;
            default: ;
         endcase
      endfunction

      // base + (tn/den)*span in Q.8, truncated toward zero
      function logic signed [OUT_BITS-1:0] locate(longint base, longint span,
                                                  longint tn, longint den);
         longint prod, q, r, v;
         prod = tn * (span < 0 ? -span : span) * 256;
         q = prod / den;
         r = prod % den;
         if (span >= 0) begin
            v = base * 256 + q;
            if (r != 0 && v < 0) v = v + 1;
         end else begin
            v = base * 256 - q;
            if (r != 0 && v > 0) v = v - 1;
         end
         return v[OUT_BITS-1:0];
      endfunction

      function void note_query(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] bx, logic signed [15:0] by);
         longint qx, qy, rx, ry, px, py, sx, sy, dx, dy, den, tn, un;
         crossing_type e;
         qx = ax; qy = ay; rx = longint'(bx) - qx; ry = longint'(by) - qy;
         px = seg_ax; py = seg_ay;
         sx = longint'(seg_bx) - px; sy = longint'(seg_by) - py;
         dx = px - qx; dy = py - qy;
         den = rx * sy - ry * sx;
         tn = dx * sy - dy * sx;
         un = dx * ry - dy * rx;
         e.hit = 0; e.cx = 0; e.cy = 0;
         if (den != 0) begin
            if (den < 0) begin
               den = -den; tn = -tn; un = -un;
            end
            if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
               e.hit = 1;
               e.cx = locate(qx, rx, tn, den);
               e.cy = locate(qy, ry, tn, den);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_crossing(logic h, logic signed [OUT_BITS-1:0] x,
                                   logic signed [OUT_BITS-1:0] y);
         crossing_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result hit=%0d x=%0d y=%0d", $time, h, x, y);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (h !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, h);
            errors++;
         end
         if (x !== e.cx) begin
            $display("%0t: cross_x expected %0d actual %0d", $time, e.cx, x);
            errors++;
         end
         if (y !== e.cy) begin
            $display("%0t: cross_y expected %0d actual %0d", $time, e.cy, y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_query_start_x = 0, req_query_start_y = 0;
   logic signed [15:0] req_query_end_x = 0, req_query_end_y = 0;
   logic rsp_valid, rsp_hit;
   logic signed [OUT_BITS-1:0] rsp_cross_x, rsp_cross_y;
   logic csr_write = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = 0;
   logic [15:0] csr_data = 0;

   crossing_board board = new();

   segment_intersection dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid)
         board.check_crossing(rsp_hit, rsp_cross_x, rsp_cross_y);

   // Leave csr_write high; the caller drops it after the last write.
   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_reference(logic [15:0] ax, logic [15:0] ay,
                                logic [15:0] bx, logic [15:0] by);
      drain();
      write_reg(CSR_REF_START_X, ax);
      write_reg(CSR_REF_START_Y, ay);
      write_reg(CSR_REF_END_X, bx);
      write_reg(CSR_REF_END_Y, by);
      csr_write <= 0;
   endtask

   // Called after a rising edge; hold start until the transaction is taken.
   // Start stays high on return so back-to-back transactions need no gap.
   task automatic send_query(logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] bx, logic [15:0] by, int gap);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_query_start_x <= ax;
      req_query_start_y <= ay;
      req_query_end_x <= bx;
      req_query_end_y <= by;
      do @(posedge clock); while (busy);
      board.note_query(ax, ay, bx, by);
   endtask

   function automatic logic [15:0] pick_coord(int span);
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return $urandom;
      if (k == 1) return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      return 16'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   initial begin
      #200000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int span, gap;
      logic [15:0] ax, ay, bx, by;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: crossing, parallel, touching ends, extremes
      set_reference(16'hfff6, 0, 10, 0);
      send_query(0, 16'hfff6, 0, 10, 0);
      send_query(3, 16'hfffb, 7, 5, 0);
      send_query(16'hfff6, 1, 10, 1, 0);
      send_query(16'hfff6, 0, 10, 0, 0);
      send_query(10, 0, 10, 5, 0);
      send_query(11, 16'hfffb, 11, 5, 0);
      send_query(5, 5, 5, 5, 0);
      send_query(0, 16'hffff, 1, 2, 0);
      set_reference(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
      send_query(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 0);
      send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0);
      send_query(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 0);
      send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 0);
      send_query(16'hffff, 16'h0001, 16'h0003, 16'hfffe, 0);
      set_reference(0, 0, 0, 0);
      send_query(0, 0, 5, 5, 0);
      set_reference(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);

      for (int phase = 0; phase < 6; phase++) begin
         span = (phase % 3 == 0) ? 32767 : (phase % 3 == 1) ? 1000 : 20;
         if (phase > 0)
            set_reference(pick_coord(span), pick_coord(span),
                          pick_coord(span), pick_coord(span));
         for (int n = 0; n < 325; n++) begin
            ax = pick_coord(span); ay = pick_coord(span);
            bx = pick_coord(span); by = pick_coord(span);
            // aim most queries across the reference segment
            if ($urandom_range(0, 3) != 0) begin
               bx = 16'(2 * (board.seg_ax + board.seg_bx) / 2 - $signed(ax));
               by = 16'(2 * (board.seg_ay + board.seg_by) / 2 - $signed(ay));
            end
            if (n >= 120 && n < 200)
               gap = 0;
            else
               gap = $urandom_range(0, 6);
            send_query(ax, ay, bx, by, gap);
            if (n == 160) drain();
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
